// ----- sv/hkd_pkg.sv -----
// Shared constants, codes and types of the hotkey combination detector.
package hkd_pkg;

  localparam int CODE_W      = 10;
  localparam int SIZE_W      = 3;
  localparam int ACT_W       = 2;
  localparam int EV_W        = 2;
  localparam int ST_W        = 2;
  localparam int OUT_CNT_W   = 6;
  localparam int KEY_REGS    = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  localparam int MAX_HELD_DEF  = 32;
  localparam int MAX_COMBO_DEF = 4;

  // opcodes
  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // key actions
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PRESS   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REPEAT  = 2'd2;

  // combo events
  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_PRESS   = 2'd1;
  localparam logic [EV_W-1:0] EV_RELEASE = 2'd2;
  localparam logic [EV_W-1:0] EV_CANCEL  = 2'd3;

  // detector states
  localparam logic [ST_W-1:0] ST_IDLE   = 2'd0;
  localparam logic [ST_W-1:0] ST_ACTIVE = 2'd1;
  localparam logic [ST_W-1:0] ST_WAIT   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_D = 3'd4;

  typedef logic [KEY_REGS-1:0][CODE_W-1:0] hkd_keys_t;

  // held set status after the current item
  typedef struct packed {
    logic                held_empty;
    logic                total_is_size;
    logic [KEY_REGS-1:0] target_held;
  } hkd_set_stat_t;

endpackage

// ----- sv/hkd_held_set.sv -----
// Held key set: slot store with parallel lookup, count and target key flags.
module hkd_held_set import hkd_pkg::*; #(
  parameter int MAX_HELD = MAX_HELD_DEF,
  localparam int CNT_W = $clog2(MAX_HELD + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic               upd,
  input  logic               down,
  input  logic [CODE_W-1:0]  code,
  input  hkd_keys_t          combo_keys,
  input  logic [SIZE_W-1:0]  combo_size,
  output hkd_set_stat_t      stat,
  output logic [CNT_W-1:0]   count_nxt
);

  localparam logic [MAX_HELD-1:0] ONE  = MAX_HELD'(1);
  localparam logic [CNT_W-1:0]    FULL = CNT_W'(MAX_HELD);

  logic [CODE_W-1:0]   keys_r [MAX_HELD];
  logic [MAX_HELD-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]    total_r;
  logic [KEY_REGS-1:0] tgt_r, tgt_nxt;

  logic [MAX_HELD-1:0] hit_vec, free_oh;
  logic                found, full, do_add, do_rem;

  always_comb begin
    for (int i = 0; i < MAX_HELD; i++) begin
      hit_vec[i] = valid_r[i] && (keys_r[i] == code);
    end
  end

  assign found   = |hit_vec;
  assign free_oh = ~valid_r & (valid_r + ONE);  // lowest free slot
  assign full    = (total_r == FULL);
  assign do_add  = upd && down && !found && !full;
  assign do_rem  = upd && !down && found;

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = total_r;
    tgt_nxt   = tgt_r;
    if (clr) begin
      valid_nxt = '0;
      count_nxt = '0;
      tgt_nxt   = '0;
    end else if (do_add) begin
      valid_nxt = valid_r | free_oh;
      count_nxt = total_r + CNT_W'(1);
      for (int k = 0; k < KEY_REGS; k++) begin
        if (combo_keys[k] == code) tgt_nxt[k] = 1'b1;
      end
    end else if (do_rem) begin
      valid_nxt = valid_r & ~hit_vec;
      count_nxt = total_r - CNT_W'(1);
      for (int k = 0; k < KEY_REGS; k++) begin
        if (combo_keys[k] == code) tgt_nxt[k] = 1'b0;
      end
    end
  end

  always_comb begin
    stat.held_empty    = (count_nxt == '0);
    stat.total_is_size = (count_nxt == CNT_W'(combo_size));
    stat.target_held   = tgt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      total_r <= '0;
      tgt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      total_r <= count_nxt;
      tgt_r   <= tgt_nxt;
    end
  end

  // codes need no reset, a slot is only read while valid
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_HELD; i++) begin
      if (!clr && do_add && free_oh[i]) keys_r[i] <= code;
    end
  end

endmodule

// ----- sv/hkd_combo_fsm.sv -----
// Combo state machine: idle, combo active, waiting for all keys released.
module hkd_combo_fsm import hkd_pkg::*; #(
  parameter int MAX_COMBO = MAX_COMBO_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              upd,
  input  logic              down,
  input  logic [CODE_W-1:0] code,
  input  hkd_keys_t         combo_keys,
  input  logic [SIZE_W-1:0] combo_size,
  input  hkd_set_stat_t     stat,
  output logic [EV_W-1:0]   event_nxt,
  output logic [ST_W-1:0]   state_nxt,
  output logic              flag_nxt
);

  logic [ST_W-1:0]     state_r;
  logic                flag_r;
  logic                usable, match, is_target;
  logic [KEY_REGS-1:0] in_combo, code_hit;

  assign usable = (int'(combo_size) <= MAX_COMBO) && (int'(combo_size) <= KEY_REGS);

  always_comb begin
    for (int k = 0; k < KEY_REGS; k++) begin
      in_combo[k] = (k < int'(combo_size));
      code_hit[k] = in_combo[k] && (combo_keys[k] == code);
    end
  end

  assign match     = usable && (combo_size != '0) && stat.total_is_size
                     && (&(stat.target_held | ~in_combo));
  assign is_target = usable && (|code_hit);

  always_comb begin
    event_nxt = EV_NONE;
    state_nxt = state_r;
    flag_nxt  = flag_r;
    if (clr) begin
      state_nxt = ST_IDLE;
      flag_nxt  = 1'b0;
    end else if (upd) begin
      unique case (state_r)
        ST_IDLE: begin
          if (down && match) begin
            state_nxt = ST_ACTIVE;
            flag_nxt  = 1'b1;
            event_nxt = EV_PRESS;
          end
        end
        ST_ACTIVE: begin
          if (down && !is_target) begin
            state_nxt = ST_WAIT;
            flag_nxt  = 1'b0;
            event_nxt = EV_CANCEL;
          end else if (!down && !match) begin
            state_nxt = stat.held_empty ? ST_IDLE : ST_WAIT;
            flag_nxt  = 1'b0;
            event_nxt = EV_RELEASE;
          end
        end
        ST_WAIT: begin
          if (stat.held_empty) state_nxt = ST_IDLE;
        end
        default: begin
          state_nxt = ST_IDLE;
          flag_nxt  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      flag_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flag_r  <= flag_nxt;
    end
  end

endmodule

// ----- sv/hotkey_combo_detector.sv -----
// Top level of the hotkey combination detector.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one key event item: opcode,
//   key code and action (release, press, repeat). Opcode clear empties the
//   held set and returns the detector to idle. Result channel
//   (out_valid/out_ready) returns exactly one item per input item: combo
//   event, detector state, held key count and combo flag after that item.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 size,
//   1..4 combo keys); any valid write also clears the held set and state.
//   Writes must be made only while no item is in flight; the block does not enforce it.
// Timing:
//   out_valid rises once an accepted item has passed the input register,
//   then the lookup over all held slots and the state machine update into
//   the result register. One item per cycle is sustained while out_ready
//   stays high; the combinational held slot compare and state update allow
//   that rate.
// Reset (synchronous, active low): empty set, idle, configuration zero.
// Stalls: while out_ready is low with a result waiting, the input register
//   holds and in_ready drops only once it is occupied too.
module hotkey_combo_detector import hkd_pkg::*; #(
  parameter int MAX_HELD  = MAX_HELD_DEF,
  parameter int MAX_COMBO = MAX_COMBO_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [CODE_W-1:0]     in_key_code,
  input  logic [ACT_W-1:0]      in_key_action,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [EV_W-1:0]       out_combo_event,
  output logic [ST_W-1:0]       out_detector_state,
  output logic [OUT_CNT_W-1:0]  out_held_count,
  output logic                  out_combo_held,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_HELD + 1);

  // configuration registers
  logic [SIZE_W-1:0] size_r;
  hkd_keys_t         keys_r;
  logic              cfg_hit;

  always_comb begin
    unique case (cfg_index) inside
      CFG_SIZE, CFG_KEY_A, CFG_KEY_B, CFG_KEY_C, CFG_KEY_D: cfg_hit = cfg_we;
      default:                                             cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
      keys_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SIZE:  size_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_KEY_A: keys_r[0] <= cfg_wdata[CODE_W-1:0];
        CFG_KEY_B: keys_r[1] <= cfg_wdata[CODE_W-1:0];
        CFG_KEY_C: keys_r[2] <= cfg_wdata[CODE_W-1:0];
        CFG_KEY_D: keys_r[3] <= cfg_wdata[CODE_W-1:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // input register
  logic              s1_vld_r;
  logic              s1_op_r;
  logic [CODE_W-1:0] s1_code_r;
  logic [ACT_W-1:0]  s1_act_r;
  logic              out_vld_r;
  logic              advance, process, upd, clr, down;

  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !s1_vld_r || advance;
  assign process  = s1_vld_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= in_opcode;
      s1_code_r <= in_key_code;
      s1_act_r  <= in_key_action;
    end
  end

  // repeats and the unused action code touch nothing
  assign upd  = process && (s1_op_r == OP_KEY)
                && ((s1_act_r == ACT_PRESS) || (s1_act_r == ACT_RELEASE));
  assign clr  = cfg_hit || (process && (s1_op_r == OP_CLEAR));
  assign down = (s1_act_r == ACT_PRESS);

  hkd_set_stat_t    stat;
  logic [CNT_W-1:0] count_nxt;
  logic [EV_W-1:0]  event_nxt;
  logic [ST_W-1:0]  state_nxt;
  logic             flag_nxt;

  hkd_held_set #(.MAX_HELD(MAX_HELD)) u_set (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (clr),
    .upd        (upd),
    .down       (down),
    .code       (s1_code_r),
    .combo_keys (keys_r),
    .combo_size (size_r),
    .stat       (stat),
    .count_nxt  (count_nxt)
  );

  hkd_combo_fsm #(.MAX_COMBO(MAX_COMBO)) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr        (clr),
    .upd        (upd),
    .down       (down),
    .code       (s1_code_r),
    .combo_keys (keys_r),
    .combo_size (size_r),
    .stat       (stat),
    .event_nxt  (event_nxt),
    .state_nxt  (state_nxt),
    .flag_nxt   (flag_nxt)
  );

  // result register
  logic [EV_W-1:0]      ev_r;
  logic [ST_W-1:0]      st_r;
  logic [OUT_CNT_W-1:0] cnt_r;
  logic                 flag_r;
  logic [CNT_W:0]       count_ext;

  assign count_ext = {1'b0, count_nxt};  // room for narrow MAX_HELD

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (process) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      ev_r   <= event_nxt;
      st_r   <= state_nxt;
      cnt_r  <= OUT_CNT_W'(count_ext);
      flag_r <= flag_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_combo_event    = ev_r;
  assign out_detector_state = st_r;
  assign out_held_count     = cnt_r;
  assign out_combo_held     = flag_r;

endmodule

// ----- tb/hotkey_combo_detector_test.sv -----
// Self-checking testbench for the hotkey combination detector.
`timescale 1ns / 1ps

module hotkey_combo_detector_test import hkd_pkg::*; ();

  // action code with no meaning; the block must ignore it like a repeat
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int LONG_HOLD   = 80;

  // one result item as the block should present it
  typedef struct packed {
    logic [EV_W-1:0]      ev;
    logic [ST_W-1:0]      st;
    logic [OUT_CNT_W-1:0] cnt;
    logic                 flag;
  } outcome_t;

  // Tracks the held set and detector state, queues the outcome of each
  // accepted item and checks returned results against that queue.
  class combo_tracker;
    logic [SIZE_W-1:0]       combo_len;
    logic [CODE_W-1:0]       combo_code [KEY_REGS];
    logic [CODE_W-1:0]       slot_code [MAX_HELD_DEF];
    logic [MAX_HELD_DEF-1:0] slot_used;
    int unsigned             held_num;
    logic [ST_W-1:0]         mode;
    logic                    combo_on;
    outcome_t                expected_outcomes [$];
    int unsigned             mismatches;
    int unsigned             checked;
    int unsigned             event_seen [4];

    function new();
      combo_len = '0;
      foreach (combo_code[i]) combo_code[i] = '0;
      foreach (event_seen[i]) event_seen[i] = 0;
      mismatches = 0;
      checked = 0;
      empty_set();
    endfunction

    function void empty_set();
      slot_used = '0;
      held_num = 0;
      mode = ST_IDLE;
      combo_on = 1'b0;
    endfunction

    function int slot_of(logic [CODE_W-1:0] code);
      for (int i = 0; i < MAX_HELD_DEF; i++)
        if (slot_used[i] && slot_code[i] == code) return i;
      return -1;
    endfunction

    // new key goes into the lowest free slot; dropped when full
    function void hold_key(logic [CODE_W-1:0] code);
      if (slot_of(code) >= 0 || held_num >= MAX_HELD_DEF) return;
      for (int i = 0; i < MAX_HELD_DEF; i++) begin
        if (!slot_used[i]) begin
          slot_code[i] = code;
          slot_used[i] = 1'b1;
          held_num++;
          return;
        end
      end
    endfunction

    function void drop_key(logic [CODE_W-1:0] code);
      int s;
      s = slot_of(code);
      if (s < 0) return;
      slot_used[s] = 1'b0;
      held_num--;
    endfunction

    function bit len_ok();
      return combo_len <= MAX_COMBO_DEF && combo_len <= KEY_REGS;
    endfunction

    function bit combo_complete();
      if (combo_len == 0 || !len_ok() || held_num != combo_len) return 0;
      for (int i = 0; i < combo_len; i++)
        if (slot_of(combo_code[i]) < 0) return 0;
      return 1;
    endfunction

    function bit combo_member(logic [CODE_W-1:0] code);
      if (!len_ok()) return 0;
      for (int i = 0; i < combo_len; i++)
        if (combo_code[i] == code) return 1;
      return 0;
    endfunction

    // any write to a known register clears the held set too
    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SIZE:  combo_len = data[SIZE_W-1:0];
        CFG_KEY_A: combo_code[0] = data;
        CFG_KEY_B: combo_code[1] = data;
        CFG_KEY_C: combo_code[2] = data;
        CFG_KEY_D: combo_code[3] = data;
        default:   return;
      endcase
      empty_set();
    endfunction

    function void take_key_item(logic op, logic [CODE_W-1:0] code, logic [ACT_W-1:0] act);
      logic            down;
      logic [EV_W-1:0] ev;
      outcome_t        o;
      ev = EV_NONE;
      if (op == OP_CLEAR) begin
        empty_set();
      end else if (act == ACT_RELEASE || act == ACT_PRESS) begin
        down = (act == ACT_PRESS);
        if (down) hold_key(code);
        else drop_key(code);
        case (mode)
          ST_IDLE: begin
            if (down && combo_complete()) begin
              mode = ST_ACTIVE;
              combo_on = 1'b1;
              ev = EV_PRESS;
            end
          end
          ST_ACTIVE: begin
            if (down && !combo_member(code)) begin
              mode = ST_WAIT;
              combo_on = 1'b0;
              ev = EV_CANCEL;
            end else if (!down && !combo_complete()) begin
              combo_on = 1'b0;
              ev = EV_RELEASE;
              mode = (held_num == 0) ? ST_IDLE : ST_WAIT;
            end
          end
          default: begin
            if (held_num == 0) mode = ST_IDLE;
          end
        endcase
      end
      o.ev = ev;
      o.st = mode;
      o.cnt = held_num[OUT_CNT_W-1:0];
      o.flag = combo_on;
      expected_outcomes.push_back(o);
    endfunction

    function void compare_outcome(logic [EV_W-1:0] ev, logic [ST_W-1:0] st,
                                  logic [OUT_CNT_W-1:0] cnt, logic flag);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result ev=%0d st=%0d cnt=%0d flag=%0d",
                   ev, st, cnt, flag);
        return;
      end
      want = expected_outcomes.pop_front();
      checked++;
      event_seen[want.ev]++;
      if (ev !== want.ev || st !== want.st || cnt !== want.cnt || flag !== want.flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: result %0d: expected ev=%0d st=%0d cnt=%0d flag=%0d,",
                    " got ev=%0d st=%0d cnt=%0d flag=%0d"},
                   checked, want.ev, want.st, want.cnt, want.flag, ev, st, cnt, flag);
      end
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic                  in_opcode     = OP_KEY;
  logic [CODE_W-1:0]     in_key_code   = '0;
  logic [ACT_W-1:0]      in_key_action = ACT_RELEASE;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [EV_W-1:0]       out_combo_event;
  logic [ST_W-1:0]       out_detector_state;
  logic [OUT_CNT_W-1:0]  out_held_count;
  logic                  out_combo_held;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;

  combo_tracker trk = new();

  // idling percentages of the two sides, set per phase by the stimulus
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  bit          rx_hold_req = 1'b0;   // asks the receiver for a long hold-off
  int unsigned items_sent  = 0;
  int unsigned settings_written = 0;
  int unsigned cycles = 0;
  logic [CODE_W-1:0] noise_pool [4];

  hotkey_combo_detector i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_key_code        (in_key_code),
    .in_key_action      (in_key_action),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_combo_event    (out_combo_event),
    .out_detector_state (out_detector_state),
    .out_held_count     (out_held_count),
    .out_combo_held     (out_combo_held),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ERROR: no progress after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Both monitors sample at the edge, so they see the values that the
  // block saw; everything driven here changes only after the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      trk.take_key_item(in_opcode, in_key_code, in_key_action);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      trk.compare_outcome(out_combo_event, out_detector_state, out_held_count,
                          out_combo_held);
  end

  // Result side: random back-pressure, or a long hold-off on request so
  // that both pipeline stages fill and in_ready drops.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // codes beyond the usual range turn up now and then
  function automatic logic [CODE_W-1:0] rand_code();
    if ($urandom_range(0, 9) == 0) return CODE_W'($urandom_range(768, 1023));
    return CODE_W'($urandom_range(0, 767));
  endfunction

  // Offers one item; valid stays up with the payload held until accepted.
  task automatic push_key(input logic op, input logic [CODE_W-1:0] code,
                          input logic [ACT_W-1:0] act);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_key_code   <= code;
    in_key_action <= act;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic key_down(input logic [CODE_W-1:0] code);
    push_key(OP_KEY, code, ACT_PRESS);
  endtask

  task automatic key_up(input logic [CODE_W-1:0] code);
    push_key(OP_KEY, code, ACT_RELEASE);
  endtask

  // Stops offering items and waits for every outstanding result, plus the
  // block's latency, so that a register write finds it empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (trk.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    trk.apply_reg(idx, data);
  endtask

  // Size goes in the low bits; the upper bits of the word carry noise.
  task automatic program_combo(input int len, input logic [CODE_W-1:0] a, b, c, d);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom_range(0, 1023));
    w[SIZE_W-1:0] = SIZE_W'(len);
    write_reg(CFG_SIZE, w);
    write_reg(CFG_KEY_A, a);
    write_reg(CFG_KEY_B, b);
    write_reg(CFG_KEY_C, c);
    write_reg(CFG_KEY_D, d);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  // A well-formed combination: the target keys in random order with stray
  // repeats, then one of several endings, then (mostly) release of all.
  task automatic run_combo_seq();
    logic [CODE_W-1:0] down_list [$];
    logic [CODE_W-1:0] tmp;
    logic [CODE_W-1:0] keys [KEY_REGS];
    int n, j, k, ending;
    bit usable;
    usable = (trk.combo_len >= 1 && trk.combo_len <= KEY_REGS);
    n = usable ? int'(trk.combo_len) : $urandom_range(1, KEY_REGS);
    for (k = 0; k < n; k++) keys[k] = usable ? trk.combo_code[k] : rand_code();
    for (k = n - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = keys[k];
      keys[k] = keys[j];
      keys[j] = tmp;
    end
    // an extra key held beforehand spoils the match
    if ($urandom_range(0, 6) == 0) begin
      tmp = rand_code();
      key_down(tmp);
      down_list.push_back(tmp);
    end
    for (k = 0; k < n; k++) begin
      key_down(keys[k]);
      down_list.push_back(keys[k]);
      if ($urandom_range(0, 4) == 0) push_key(OP_KEY, keys[k], ACT_REPEAT);
    end
    ending = $urandom_range(0, 9);
    case (ending) inside
      4, 5: begin
        // extra key while active: cancel
        tmp = rand_code();
        key_down(tmp);
        down_list.push_back(tmp);
      end
      6: begin
        // release and press again: no new press event from waiting
        j = $urandom_range(0, down_list.size() - 1);
        key_up(down_list[j]);
        key_down(down_list[j]);
      end
      7: begin
        push_key(OP_CLEAR, rand_code(), ACT_W'($urandom_range(0, 3)));
        down_list.delete();
      end
      8: key_down(down_list[$urandom_range(0, down_list.size() - 1)]);
      9: key_up(rand_code());
      default: ;
    endcase
    // sometimes one key stays down into the next sequence
    k = ($urandom_range(0, 6) == 0) ? 1 : 0;
    while (down_list.size() > k) begin
      j = $urandom_range(0, down_list.size() - 1);
      key_up(down_list[j]);
      down_list.delete(j);
    end
  endtask

  // Random items over a small pool of codes so presses and releases collide.
  task automatic run_noise(input int count);
    logic [CODE_W-1:0] code;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 9);
      if (r < 5) code = trk.combo_code[$urandom_range(0, KEY_REGS - 1)];
      else if (r < 8) code = noise_pool[$urandom_range(0, 3)];
      else code = rand_code();
      push_key(($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_KEY, code,
               ACT_W'($urandom_range(0, 3)));
    end
  endtask

  // Enough distinct presses to overflow the held set.
  task automatic run_flood();
    logic [CODE_W-1:0] codes [$];
    int n;
    n = $urandom_range(34, 40);
    for (int k = 0; k < n; k++) begin
      codes.push_back(rand_code());
      key_down(codes[k]);
    end
    if ($urandom_range(0, 1) == 0) begin
      push_key(OP_CLEAR, rand_code(), ACT_W'($urandom_range(0, 3)));
    end else begin
      foreach (codes[k]) key_up(codes[k]);
    end
  endtask

  initial begin
    logic [CODE_W-1:0] ka, kb, kc, kd;
    int  len, phase_end, r;
    bit  mid_done;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 11;
    rx_idle_pct = 50;

    // Directed: after reset the size is zero, so nothing may match.
    key_down(10'd0);
    key_up(10'd0);
    wait_idle();
    program_combo(2, 10'd0, 10'd767, 10'd1023, 10'd512);
    key_down(10'd0);
    key_down(10'd767);                         // combo pressed
    push_key(OP_KEY, 10'd767, ACT_REPEAT);     // repeat changes nothing
    push_key(OP_KEY, 10'd1023, ACT_UNUSED);    // unused action ignored too
    key_down(10'd0);                           // already held
    key_up(10'd767);                           // combo released, one left
    key_up(10'd100);                           // release of a key not held
    key_up(10'd0);                             // set empty: back to idle
    key_down(10'd0);
    key_down(10'd767);
    key_down(10'd1023);                        // extra key cancels
    push_key(OP_CLEAR, 10'h3FF, ACT_UNUSED);   // clear ignores code and action
    key_down(10'd767);
    key_down(10'd0);
    key_up(10'd0);
    key_up(10'd767);
    wait_idle();

    // Random phases, each under its own register setting; the idling
    // regime changes every four phases and the last four run flat out.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 4)
        0: begin tx_idle_pct = 11; rx_idle_pct = 50; end
        1: begin tx_idle_pct = 50; rx_idle_pct = 11; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      ka = rand_code();
      kb = rand_code();
      kc = rand_code();
      kd = rand_code();
      case (ph)
        0: len = 4;
        1: begin len = 1; ka = '0; end
        2: begin len = 3; ka = 10'd767; kb = 10'd766; kc = '0; end
        3: len = 2;
        4: len = 0;                                  // never matches
        5: begin len = 3; kb = ka; end               // repeated target code
        6: begin len = 4; ka = 10'd767; kb = '0; kc = 10'h3FF; end
        7: len = 5;                                  // size beyond the key list
        8: len = 7;
        9: begin len = 1; ka = 10'h3FF; end
        10: len = 2;
        default: len = 4;
      endcase
      foreach (noise_pool[i]) noise_pool[i] = rand_code();
      program_combo(len, ka, kb, kc, kd);
      phase_end = items_sent + PHASE_ITEMS;
      mid_done = 1'b0;
      while (items_sent < phase_end) begin
        if (!mid_done && items_sent + PHASE_ITEMS / 2 >= phase_end) begin
          mid_done = 1'b1;
          if (ph == 1 || ph == 9) rx_hold_req = 1'b1;
          if (ph == 5) wait_idle();
          if (ph == 2 || ph == 7 || ph == 10) begin
            // write to a register that does not exist: no clearing
            wait_idle();
            write_reg(CFG_IDX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom_range(0, 1023)));
            cfg_we <= 1'b0;
          end
        end
        r = $urandom_range(0, 19);
        if (r < 14) run_combo_seq();
        else if (r < 19) run_noise($urandom_range(4, 12));
        else run_flood();
      end
      wait_idle();
    end

    if (trk.pending() != 0)
      $display("ERROR: %0d expected results never arrived", trk.pending());
    $display("Covered %0d key items under %0d register settings, %0d results checked.",
             items_sent, settings_written, trk.checked);
    $display("Outcomes: %0d combo pressed, %0d released, %0d cancelled; %0d mismatches.",
             trk.event_seen[EV_PRESS], trk.event_seen[EV_RELEASE],
             trk.event_seen[EV_CANCEL], trk.mismatches);
    if (trk.mismatches == 0 && trk.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
